// ===== hw/rtl/bls_pkg.sv =====
// Package for the Bresenham line stepper: coordinate widths, the item and
// pixel structs and the status struct passed from the core to the top level.
// No dependencies.
package bls_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DELTA_WIDTH = COORD_WIDTH + 1;
    localparam int DEC_WIDTH   = COORD_WIDTH + 4;
    localparam int COLOR_WIDTH = 24;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef struct packed {
        logic                          mode;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic [COLOR_WIDTH-1:0]        line_color;
    } item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pixel_x;
        logic signed [COORD_WIDTH-1:0] pixel_y;
        logic [COLOR_WIDTH-1:0]        pixel_color;
        logic                          last_pixel;
    } pixel_t;

    typedef struct packed {
        logic active;
        logic emit;
    } core_status_t;

endpackage

// ===== hw/rtl/bls_core.sv =====
// Line state and per-item logic of the Bresenham line stepper: octant setup
// on a load item, one pixel and one decision update on a step item.
// Depends on bls_pkg.
module bls_core import bls_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         fire_i,
    input  item_t        item_i,
    output pixel_t       pix_o,
    output core_status_t status_o
);

    logic                          active_reg, active_next;
    logic                          steep_reg, steep_next;
    logic signed [COORD_WIDTH-1:0] major_pos_reg, major_pos_next;
    logic signed [COORD_WIDTH-1:0] minor_pos_reg, minor_pos_next;
    logic signed [COORD_WIDTH-1:0] major_stop_reg, major_stop_next;
    logic [DELTA_WIDTH-1:0]        major_delta_reg, major_delta_next;
    logic [DELTA_WIDTH-1:0]        minor_delta_reg, minor_delta_next;
    logic                          minor_dir_reg, minor_dir_next;
    logic signed [DEC_WIDTH-1:0]   decision_reg, decision_next;
    logic [COLOR_WIDTH-1:0]        color_reg, color_next;

    // load setup
    logic signed [DELTA_WIDTH-1:0] dx, dy, dmin_raw, dmin;
    logic [DELTA_WIDTH-1:0]        adx, ady, majd_ld, mind_ld;
    logic                          steep_ld, swap_ld;
    logic signed [COORD_WIDTH-1:0] ma0, mi0, ma1;

    // step
    logic signed [DELTA_WIDTH-1:0] major_inc;
    logic                          last;
    logic                          emit;
    logic signed [DEC_WIDTH-1:0]   majd_ext, mind_ext;

    always_comb begin
        dx = DELTA_WIDTH'(item_i.end_x) - DELTA_WIDTH'(item_i.start_x);
        dy = DELTA_WIDTH'(item_i.end_y) - DELTA_WIDTH'(item_i.start_y);
        adx = dx[DELTA_WIDTH-1] ? -dx : dx;
        ady = dy[DELTA_WIDTH-1] ? -dy : dy;
        // a tie in length counts as steep
        steep_ld = !(ady < adx);
        // swap so that the major axis counts upward
        swap_ld = steep_ld ? dy[DELTA_WIDTH-1] : dx[DELTA_WIDTH-1];
        if (steep_ld) begin
            ma0 = swap_ld ? item_i.end_y : item_i.start_y;
            ma1 = swap_ld ? item_i.start_y : item_i.end_y;
            mi0 = swap_ld ? item_i.end_x : item_i.start_x;
            majd_ld  = ady;
            dmin_raw = dx;
        end else begin
            ma0 = swap_ld ? item_i.end_x : item_i.start_x;
            ma1 = swap_ld ? item_i.start_x : item_i.end_x;
            mi0 = swap_ld ? item_i.end_y : item_i.start_y;
            majd_ld  = adx;
            dmin_raw = dy;
        end
        dmin    = swap_ld ? -dmin_raw : dmin_raw;
        mind_ld = dmin[DELTA_WIDTH-1] ? -dmin : dmin;
    end

    always_comb begin
        major_inc = DELTA_WIDTH'(major_pos_reg) + DELTA_WIDTH'(1);
        last      = !(major_inc < DELTA_WIDTH'(major_stop_reg));
        emit      = fire_i && (item_i.mode == MODE_STEP) && active_reg;
        majd_ext  = DEC_WIDTH'(major_delta_reg);
        mind_ext  = DEC_WIDTH'(minor_delta_reg);

        pix_o.pixel_x     = steep_reg ? minor_pos_reg : major_pos_reg;
        pix_o.pixel_y     = steep_reg ? major_pos_reg : minor_pos_reg;
        pix_o.pixel_color = color_reg;
        pix_o.last_pixel  = last;

        status_o.active = active_reg;
        status_o.emit   = emit;
    end

    always_comb begin
        active_next      = active_reg;
        steep_next       = steep_reg;
        major_pos_next   = major_pos_reg;
        minor_pos_next   = minor_pos_reg;
        major_stop_next  = major_stop_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        minor_dir_next   = minor_dir_reg;
        decision_next    = decision_reg;
        color_next       = color_reg;
        if (fire_i && item_i.mode == MODE_LOAD) begin
            color_next       = item_i.line_color;
            steep_next       = steep_ld;
            major_pos_next   = ma0;
            major_stop_next  = ma1;
            minor_pos_next   = mi0;
            major_delta_next = majd_ld;
            minor_delta_next = mind_ld;
            minor_dir_next   = dmin[DELTA_WIDTH-1];
            decision_next    = (DEC_WIDTH'(mind_ld) <<< 1) - DEC_WIDTH'(majd_ld);
            active_next      = (majd_ld != '0);
        end else if (emit) begin
            // zero decision holds the minor axis
            if (!decision_reg[DEC_WIDTH-1] && decision_reg != '0) begin
                minor_pos_next = minor_dir_reg ? minor_pos_reg - COORD_WIDTH'(1)
                                               : minor_pos_reg + COORD_WIDTH'(1);
                decision_next  = decision_reg + ((mind_ext - majd_ext) <<< 1);
            end else begin
                decision_next  = decision_reg + (mind_ext <<< 1);
            end
            major_pos_next = major_inc[COORD_WIDTH-1:0];
            active_next    = !last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            steep_reg       <= 1'b0;
            major_pos_reg   <= '0;
            minor_pos_reg   <= '0;
            major_stop_reg  <= '0;
            major_delta_reg <= '0;
            minor_delta_reg <= '0;
            minor_dir_reg   <= 1'b0;
            decision_reg    <= '0;
            color_reg       <= '0;
        end else begin
            active_reg      <= active_next;
            steep_reg       <= steep_next;
            major_pos_reg   <= major_pos_next;
            minor_pos_reg   <= minor_pos_next;
            major_stop_reg  <= major_stop_next;
            major_delta_reg <= major_delta_next;
            minor_delta_reg <= minor_delta_next;
            minor_dir_reg   <= minor_dir_next;
            decision_reg    <= decision_next;
            color_reg       <= color_next;
        end
    end

endmodule

// ===== hw/rtl/bresenham_line_stepper.sv =====
// Top level of the Bresenham line stepper: input register, output register
// and stream handshake around bls_core. Depends on bls_pkg and bls_core.
//
//   channel  direction  tdata                          tuser  tlast
//   s_       in         start/end coords, line_color   mode   -
//   m_       out        pixel_x, pixel_y, pixel_color  -      last_pixel
//
// One item per clock unless the output register stalls. An item is held in the
// input register and worked in a single pass by bls_core; its pixel is valid
// on m_ from the output register. Only the output register can stall the flow,
// and only for step items that emit a pixel; loads and idle steps pass anyway.
// Synchronous active-low reset clears the line (no active line, zero state).
module bresenham_line_stepper import bls_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] start_x, [31:16] start_y, [47:32] end_x, [63:48] end_y,
    // [87:64] line_color
    input  logic [87:0] s_tdata,
    // [0] mode
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] pixel_x, [31:16] pixel_y, [55:32] pixel_color
    output logic [55:0] m_tdata,
    output logic        m_tlast
);

    logic         in_valid_reg, in_valid_next;
    item_t        in_item_reg;
    logic         out_valid_reg, out_valid_next;
    pixel_t       out_pix_reg;
    pixel_t       core_pix;
    core_status_t core_stat;
    logic         s_accept, out_space, proc_fire, needs_out;

    always_comb begin
        out_space = !out_valid_reg || m_tready;
        needs_out = (in_item_reg.mode == MODE_STEP) && core_stat.active;
        proc_fire = in_valid_reg && (!needs_out || out_space);
        s_tready  = !in_valid_reg || proc_fire;
        s_accept  = s_tvalid && s_tready;

        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (core_stat.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.mode       <= s_tuser;
            in_item_reg.start_x    <= s_tdata[15:0];
            in_item_reg.start_y    <= s_tdata[31:16];
            in_item_reg.end_x      <= s_tdata[47:32];
            in_item_reg.end_y      <= s_tdata[63:48];
            in_item_reg.line_color <= s_tdata[87:64];
        end
        if (core_stat.emit) begin
            out_pix_reg <= core_pix;
        end
    end

    bls_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire_i   (proc_fire),
        .item_i   (in_item_reg),
        .pix_o    (core_pix),
        .status_o (core_stat)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pix_reg.pixel_color, out_pix_reg.pixel_y, out_pix_reg.pixel_x};
    assign m_tlast  = out_pix_reg.last_pixel;

    // a pixel is only produced when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        core_stat.emit |-> (!out_valid_reg || m_tready))
        else $error("pixel produced into a full output register");

    // a held item is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !proc_fire) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input register lost an item");

    // the last pixel ends the line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (core_stat.emit && core_pix.last_pixel) |=> !core_stat.active)
        else $error("line still active after its last pixel");

endmodule
